// ===== rtl/lfid_pkg.sv =====
// Shared constants, codes and the 64-bit lowest-set-bit search for the
// lowest free ID allocator. No dependencies.
package lfid_pkg;

    localparam int BASE_ID          = 300;
    localparam int POOL_SIZE_DEFAULT = 4096;

    localparam int ID_W     = 16;
    localparam int STATUS_W = 2;

    // free map word: 64 identifiers per RAM word, 64 words per summary word
    localparam int WORD_W  = 64;
    localparam int WBIT_W  = 6;

    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd2;

    // binary-halving search: six narrow dependent steps
    function automatic logic [WBIT_W-1:0] lowest_set64(input logic [WORD_W-1:0] v);
        logic [WBIT_W-1:0] idx;
        logic [31:0]       h32;
        logic [15:0]       h16;
        logic [7:0]        h8;
        logic [3:0]        h4;
        logic [1:0]        h2;
        idx[5] = (v[31:0] == '0);
        h32    = idx[5] ? v[63:32] : v[31:0];
        idx[4] = (h32[15:0] == '0);
        h16    = idx[4] ? h32[31:16] : h32[15:0];
        idx[3] = (h16[7:0] == '0);
        h8     = idx[3] ? h16[15:8] : h16[7:0];
        idx[2] = (h8[3:0] == '0);
        h4     = idx[2] ? h8[7:4] : h8[3:0];
        idx[1] = (h4[1:0] == '0);
        h2     = idx[1] ? h4[3:2] : h4[1:0];
        idx[0] = !h2[0];
        return idx;
    endfunction

endpackage

// ===== rtl/lfid_if.sv =====
// Request and response channel interfaces (valid/ready) of the allocator.
// Depends on lfid_pkg.
interface lfid_req_if import lfid_pkg::*; ();
    logic            valid;
    logic            ready;
    logic            cmd;
    logic [ID_W-1:0] release_id;

    modport source (output valid, output cmd, output release_id, input ready);
    modport sink   (input valid, input cmd, input release_id, output ready);
endinterface

interface lfid_rsp_if import lfid_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ID_W-1:0]     granted_id;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output granted_id, output status, input ready);
    modport sink   (input valid, input granted_id, input status, output ready);
endinterface

// ===== rtl/lfid_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module lfid_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/lowest_free_id_allocator_unit.sv =====
// Lowest free ID allocator: first-fit over a free bitmap held in RAM, with a
// summary RAM (one bit per non-empty map word) and a summary-of-summary register.
// An allocate makes two dependent RAM reads, summary word then map word; an
// in-range release reads both at once. Results wait for room in the output.
// One item at a time: next beat taken the cycle after the result is registered.
// After reset a clearing pass writes every map word.
module lowest_free_id_allocator_unit
    import lfid_pkg::*;
#(
    parameter int POOL_SIZE = POOL_SIZE_DEFAULT
) (
    input  logic   clk,
    input  logic   rst_n,
    lfid_req_if.sink   req,
    lfid_rsp_if.source rsp
);

    localparam int NWORDS  = (POOL_SIZE + WORD_W - 1) / WORD_W;
    localparam int WADDR_W = NWORDS > 1 ? $clog2(NWORDS) : 1;
    localparam int NL1     = (NWORDS + WORD_W - 1) / WORD_W;
    localparam int L1A_W   = NL1 > 1 ? $clog2(NL1) : 1;

    localparam int D_REM  = POOL_SIZE % WORD_W;
    localparam int L1_REM = NWORDS % WORD_W;
    localparam logic [WORD_W-1:0] D_LAST  =
        D_REM == 0 ? '1 : WORD_W'((64'd1 << D_REM) - 64'd1);
    localparam logic [WORD_W-1:0] L1_LAST =
        L1_REM == 0 ? '1 : WORD_W'((64'd1 << L1_REM) - 64'd1);
    localparam logic [NL1-1:0] TOP_INIT = '1;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_A_L1  = 3'd2;
    localparam logic [2:0] S_A_MAP = 3'd3;
    localparam logic [2:0] S_R_WR  = 3'd4;
    localparam logic [2:0] S_RESP  = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [WADDR_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [NL1-1:0]      top_reg, top_next;
    logic [L1A_W-1:0]    l1idx_reg, l1idx_next;
    logic [WORD_W-1:0]   l1word_reg, l1word_next;
    logic [WADDR_W-1:0]  widx_reg, widx_next;
    logic [WBIT_W-1:0]   rbit_reg, rbit_next;
    logic [WBIT_W-1:0]   l1bit_reg, l1bit_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic                out_valid_reg, out_valid_next;
    logic [ID_W-1:0]     out_granted_reg, out_granted_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;

    logic                d_we, d_re, l1_we, l1_re;
    logic [WADDR_W-1:0]  d_waddr, d_raddr;
    logic [L1A_W-1:0]    l1_waddr, l1_raddr;
    logic [WORD_W-1:0]   d_wdata, d_rdata, l1_wdata, l1_rdata;

    logic                out_room;
    logic [16:0]         rel_diff;
    logic                rel_in_range;
    logic [L1A_W-1:0]    top_idx;
    logic [WBIT_W-1:0]   l1_hit;
    logic [WBIT_W-1:0]   d_hit;
    logic [WORD_W-1:0]   d_cleared;
    logic [WORD_W-1:0]   l1_cleared;
    logic [16:0]         grant_full;

    lfid_ram #(.WIDTH(WORD_W), .DEPTH(NWORDS)) u_map_ram (
        .clk   (clk),
        .we    (d_we),
        .waddr (d_waddr),
        .wdata (d_wdata),
        .re    (d_re),
        .raddr (d_raddr),
        .rdata (d_rdata)
    );

    lfid_ram #(.WIDTH(WORD_W), .DEPTH(NL1)) u_sum_ram (
        .clk   (clk),
        .we    (l1_we),
        .waddr (l1_waddr),
        .wdata (l1_wdata),
        .re    (l1_re),
        .raddr (l1_raddr),
        .rdata (l1_rdata)
    );

    assign req.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = out_valid_reg;
    assign rsp.granted_id = out_granted_reg;
    assign rsp.status     = out_status_reg;

    assign out_room     = !out_valid_reg || rsp.ready;
    assign rel_diff     = {1'b0, req.release_id} - 17'(BASE_ID);
    assign rel_in_range = (req.release_id >= ID_W'(BASE_ID)) &&
                          (rel_diff < 17'(POOL_SIZE));
    assign top_idx      = L1A_W'(lowest_set64(WORD_W'(top_reg)));
    assign l1_hit       = lowest_set64(l1_rdata);
    assign d_hit        = lowest_set64(d_rdata);
    assign d_cleared    = d_rdata & ~(64'd1 << d_hit);
    assign l1_cleared   = l1word_reg & ~(64'd1 << l1bit_reg);
    assign grant_full   = 17'(BASE_ID) + (17'(widx_reg) << WBIT_W) + 17'(d_hit);

    always_comb
    begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        top_next         = top_reg;
        l1idx_next       = l1idx_reg;
        l1word_next      = l1word_reg;
        widx_next        = widx_reg;
        rbit_next        = rbit_reg;
        l1bit_next       = l1bit_reg;
        res_status_next  = res_status_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_granted_next = out_granted_reg;
        out_status_next  = out_status_reg;

        d_we     = 1'b0;
        d_waddr  = widx_reg;
        d_wdata  = d_rdata;
        d_re     = 1'b0;
        d_raddr  = widx_reg;
        l1_we    = 1'b0;
        l1_waddr = l1idx_reg;
        l1_wdata = l1_rdata;
        l1_re    = 1'b0;
        l1_raddr = l1idx_reg;

        case (state_reg)
            S_CLEAR:
            begin
                d_we    = 1'b1;
                d_waddr = clr_cnt_reg;
                d_wdata = (clr_cnt_reg == WADDR_W'(NWORDS - 1)) ? D_LAST : '1;
                if (32'(clr_cnt_reg) < NL1)
                begin
                    l1_we    = 1'b1;
                    l1_waddr = L1A_W'(clr_cnt_reg);
                    l1_wdata = (32'(clr_cnt_reg) == NL1 - 1) ? L1_LAST : '1;
                end
                if (clr_cnt_reg == WADDR_W'(NWORDS - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.cmd == CMD_ALLOC)
                    begin
                        if (top_reg == '0)
                        begin
                            res_status_next = ST_EXHAUSTED;
                            state_next      = S_RESP;
                        end
                        else
                        begin
                            l1_re      = 1'b1;
                            l1_raddr   = top_idx;
                            l1idx_next = top_idx;
                            state_next = S_A_L1;
                        end
                    end
                    else if (rel_in_range)
                    begin
                        d_re       = 1'b1;
                        d_raddr    = WADDR_W'(rel_diff >> WBIT_W);
                        l1_re      = 1'b1;
                        l1_raddr   = L1A_W'(rel_diff >> (2 * WBIT_W));
                        widx_next  = WADDR_W'(rel_diff >> WBIT_W);
                        l1idx_next = L1A_W'(rel_diff >> (2 * WBIT_W));
                        rbit_next  = rel_diff[WBIT_W-1:0];
                        l1bit_next = rel_diff[2*WBIT_W-1:WBIT_W];
                        state_next = S_R_WR;
                    end
                    else
                    begin
                        res_status_next = ST_RANGE;
                        state_next      = S_RESP;
                    end
                end
            end
            S_A_L1:
            begin
                // summary word is back: pick the lowest non-empty map word
                widx_next   = WADDR_W'((16'(l1idx_reg) << WBIT_W) | 16'(l1_hit));
                d_re        = 1'b1;
                d_raddr     = WADDR_W'((16'(l1idx_reg) << WBIT_W) | 16'(l1_hit));
                l1word_next = l1_rdata;
                l1bit_next  = l1_hit;
                state_next  = S_A_MAP;
            end
            S_A_MAP:
            begin
                if (out_room)
                begin
                    d_we    = 1'b1;
                    d_waddr = widx_reg;
                    d_wdata = d_cleared;
                    if (d_cleared == '0)
                    begin
                        l1_we    = 1'b1;
                        l1_waddr = l1idx_reg;
                        l1_wdata = l1_cleared;
                        if (l1_cleared == '0)
                        begin
                            top_next[l1idx_reg] = 1'b0;
                        end
                    end
                    out_valid_next   = 1'b1;
                    out_granted_next = grant_full[ID_W-1:0];
                    out_status_next  = ST_OK;
                    state_next       = S_IDLE;
                end
            end
            S_R_WR:
            begin
                if (out_room)
                begin
                    d_we     = 1'b1;
                    d_waddr  = widx_reg;
                    d_wdata  = d_rdata | (64'd1 << rbit_reg);
                    l1_we    = 1'b1;
                    l1_waddr = l1idx_reg;
                    l1_wdata = l1_rdata | (64'd1 << l1bit_reg);
                    top_next[l1idx_reg] = 1'b1;
                    out_valid_next   = 1'b1;
                    out_granted_next = '0;
                    out_status_next  = ST_OK;
                    state_next       = S_IDLE;
                end
            end
            S_RESP:
            begin
                if (out_room)
                begin
                    out_valid_next   = 1'b1;
                    out_granted_next = '0;
                    out_status_next  = res_status_reg;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            top_reg       <= TOP_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            top_reg       <= top_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        l1idx_reg       <= l1idx_next;
        l1word_reg      <= l1word_next;
        widx_reg        <= widx_next;
        rbit_reg        <= rbit_next;
        l1bit_reg       <= l1bit_next;
        res_status_reg  <= res_status_next;
        out_granted_reg <= out_granted_next;
        out_status_reg  <= out_status_next;
    end

endmodule
